>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; every check is clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every clock edge out of reset.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition forbids another one on the same edge.
`define ASSERT_NEVER_BOTH(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) \
    else $error(msg);

`endif

>>> design/smbe_pkg.sv
// ----------------------------------------------------------------------------
// smbe_pkg
// Types and constants of the SPI master byte engine.
// ----------------------------------------------------------------------------
package smbe_pkg;

  localparam int unsigned DELAY_W  = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // Request codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_OPEN  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_CLOSE = 3'd4;

  // Device codes
  localparam logic [1:0] DEV_NONE    = 2'd0;
  localparam logic [1:0] DEV_FIRST   = 2'd1;
  localparam logic [1:0] DEV_SECOND  = 2'd2;
  localparam logic [1:0] DEV_INVALID = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DELAY = 2'd1;

  localparam logic [DELAY_W-1:0] FAST_DELAY_RST = 10'd100;
  localparam logic [DELAY_W-1:0] SLOW_DELAY_RST = 10'd400;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_OPEN  = 3'd1,
    PH_WRITE = 3'd2,
    PH_READ  = 3'd3,
    PH_CLOSE = 3'd4
  } phase_t;

  typedef struct packed {
    logic mosi;
    logic sck;
    logic cs_second_n;
    logic cs_first_n;
  } pins_t;

  localparam pins_t PINS_RST = '{mosi: 1'b1, sck: 1'b1, cs_second_n: 1'b1,
                                 cs_first_n: 1'b1};

endpackage

>>> design/spi_master_byte_engine_core.sv
// ----------------------------------------------------------------------------
// spi_master_byte_engine_core
// Path: an accepted item passes the input register, then the result
//   register, before its result can be taken.
// Throughput: one item per cycle while the result channel is not stalled.
// Reset: synchronous, active low; pins idle high, phase idle, delays 100/400.
// ----------------------------------------------------------------------------
// SPI master, mode 3 style, MSB first, two active-low chip selects.
// Each transfer on the in channel is a request (open, write byte, read byte,
// close) or a tick of the bit timer carrying the sampled MISO level. Every
// item yields exactly one result transfer holding the pin levels after it.
// Requests while a sequence runs are dropped and flagged as rejected.
// ----------------------------------------------------------------------------
module spi_master_byte_engine_core
  import smbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_command,
  input  logic [1:0]           in_chip_select,
  input  logic                 in_use_slow_clock,
  input  logic [7:0]           in_tx_byte,
  input  logic                 in_miso,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_cs_first_n,
  output logic                 out_cs_second_n,
  output logic                 out_sck,
  output logic                 out_mosi,
  output logic [7:0]           out_rx_byte,
  output logic                 out_rx_valid,
  output logic                 out_busy_res,
  output logic                 out_rejected
);

`include "assert_macros.svh"

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, unknown indexes are dropped.
  // --------------------------------------------------------------------------
  logic [DELAY_W-1:0] fast_delay_r;
  logic [DELAY_W-1:0] slow_delay_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_delay_r <= FAST_DELAY_RST;
      slow_delay_r <= SLOW_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FAST_DELAY) begin
        fast_delay_r <= cfg_wdata;
      end else if (cfg_index == CFG_SLOW_DELAY) begin
        slow_delay_r <= cfg_wdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Both stages advance together whenever the result
  // register is free or being drained, so a new transfer is taken every
  // cycle as long as the consumer keeps up.
  // --------------------------------------------------------------------------
  logic in_vld_r;
  logic out_vld_r;
  logic advance;
  logic step;

  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;
  assign step     = in_vld_r && advance;

  // Input register: hold the accepted item until the engine consumes it.
  logic [2:0] cmd_r;
  logic [1:0] chip_select_r;
  logic       use_slow_r;
  logic [7:0] tx_byte_r;
  logic       miso_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r         <= in_command;
      chip_select_r <= in_chip_select;
      use_slow_r    <= in_use_slow_clock;
      tx_byte_r     <= in_tx_byte;
      miso_r        <= in_miso;
    end
  end

  // --------------------------------------------------------------------------
  // Engine state
  // --------------------------------------------------------------------------
  phase_t             phase_r,         phase_nxt;
  logic [1:0]         sub_step_r,      sub_step_nxt;
  logic [3:0]         bits_left_r,     bits_left_nxt;
  logic [DELAY_W-1:0] wait_count_r,    wait_count_nxt;
  logic [DELAY_W-1:0] latched_delay_r, latched_delay_nxt;
  logic [7:0]         tx_shift_r,      tx_shift_nxt;
  logic [7:0]         rx_shift_r,      rx_shift_nxt;
  logic [1:0]         active_dev_r,    active_dev_nxt;
  pins_t              pins_r,          pins_nxt;
  logic [7:0]         rx_last_r,       rx_last_nxt;
  logic               rx_done;
  logic               rejected;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      sub_step_r      <= 2'd0;
      bits_left_r     <= 4'd0;
      wait_count_r    <= '0;
      latched_delay_r <= FAST_DELAY_RST;
      tx_shift_r      <= 8'd0;
      rx_shift_r      <= 8'd0;
      active_dev_r    <= DEV_NONE;
      pins_r          <= PINS_RST;
      rx_last_r       <= 8'd0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      sub_step_r      <= sub_step_nxt;
      bits_left_r     <= bits_left_nxt;
      wait_count_r    <= wait_count_nxt;
      latched_delay_r <= latched_delay_nxt;
      tx_shift_r      <= tx_shift_nxt;
      rx_shift_r      <= rx_shift_nxt;
      active_dev_r    <= active_dev_nxt;
      pins_r          <= pins_nxt;
      rx_last_r       <= rx_last_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Next state for the item in the input register.
  // A request in idle starts a sequence; a tick in a running sequence counts
  // the wait down and, when it reaches zero, performs the next pin action
  // and, unless the sequence ends there, reloads the wait.
  // --------------------------------------------------------------------------
  logic [DELAY_W-1:0] wait_dec;
  logic [3:0]         bits_dec;
  logic [7:0]         rx_merged;
  logic [1:0]         open_dev;
  logic [DELAY_W-1:0] open_delay;

  assign wait_dec   = (wait_count_r != '0) ? wait_count_r - 1'b1 : '0;
  assign bits_dec   = bits_left_r - 4'd1;
  assign rx_merged  = rx_shift_r | {7'd0, miso_r};
  assign open_dev   = (chip_select_r == DEV_INVALID) ? DEV_NONE : chip_select_r;
  assign open_delay = use_slow_r ? slow_delay_r : fast_delay_r;

  always_comb begin
    phase_nxt         = phase_r;
    sub_step_nxt      = sub_step_r;
    bits_left_nxt     = bits_left_r;
    wait_count_nxt    = wait_count_r;
    latched_delay_nxt = latched_delay_r;
    tx_shift_nxt      = tx_shift_r;
    rx_shift_nxt      = rx_shift_r;
    active_dev_nxt    = active_dev_r;
    pins_nxt          = pins_r;
    rx_last_nxt       = rx_last_r;
    rx_done           = 1'b0;
    rejected          = 1'b0;

    if (cmd_r inside {[CMD_OPEN:CMD_CLOSE]}) begin
      if (phase_r != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        case (cmd_r)
          CMD_OPEN: begin
            // latch the delay and select the device; SCK drops one wait later
            active_dev_nxt    = open_dev;
            latched_delay_nxt = open_delay;
            if (open_dev == DEV_FIRST) begin
              pins_nxt.cs_first_n = 1'b0;
            end else if (open_dev == DEV_SECOND) begin
              pins_nxt.cs_second_n = 1'b0;
            end
            phase_nxt      = PH_OPEN;
            sub_step_nxt   = 2'd0;
            wait_count_nxt = open_delay;
          end
          CMD_WRITE: begin
            tx_shift_nxt   = tx_byte_r;
            bits_left_nxt  = BITS_PER_BYTE;
            pins_nxt.sck   = 1'b0;
            phase_nxt      = PH_WRITE;
            sub_step_nxt   = 2'd1;
            wait_count_nxt = latched_delay_r;
          end
          CMD_READ: begin
            rx_shift_nxt   = 8'd0;
            bits_left_nxt  = BITS_PER_BYTE;
            pins_nxt.sck   = 1'b0;
            phase_nxt      = PH_READ;
            sub_step_nxt   = 2'd1;
            wait_count_nxt = latched_delay_r;
          end
          default: begin
            // close opens with a wait
            phase_nxt      = PH_CLOSE;
            sub_step_nxt   = 2'd0;
            wait_count_nxt = latched_delay_r;
          end
        endcase
      end
    end else if (cmd_r == CMD_TICK && phase_r != PH_IDLE) begin
      wait_count_nxt = wait_dec;
      if (wait_dec == '0) begin
        case (phase_r)
          PH_OPEN: begin
            if (sub_step_r == 2'd0) begin
              pins_nxt.sck   = 1'b0;
              sub_step_nxt   = 2'd1;
              wait_count_nxt = latched_delay_r;
            end else begin
              phase_nxt    = PH_IDLE;
              sub_step_nxt = 2'd0;
            end
          end
          PH_WRITE: begin
            if (sub_step_r == 2'd1) begin
              // change MOSI while SCK is low
              pins_nxt.mosi  = tx_shift_r[7];
              sub_step_nxt   = 2'd2;
              wait_count_nxt = latched_delay_r;
            end else if (sub_step_r == 2'd2) begin
              pins_nxt.sck   = 1'b1;
              sub_step_nxt   = 2'd3;
              wait_count_nxt = latched_delay_r;
            end else begin
              tx_shift_nxt  = {tx_shift_r[6:0], 1'b0};
              bits_left_nxt = bits_dec;
              if (bits_dec == 4'd0) begin
                phase_nxt    = PH_IDLE;
                sub_step_nxt = 2'd0;
              end else begin
                pins_nxt.sck   = 1'b0;
                sub_step_nxt   = 2'd1;
                wait_count_nxt = latched_delay_r;
              end
            end
          end
          PH_READ: begin
            if (sub_step_r == 2'd1) begin
              pins_nxt.sck   = 1'b1;
              sub_step_nxt   = 2'd2;
              wait_count_nxt = latched_delay_r;
            end else begin
              // sample MISO one wait after the rising edge
              bits_left_nxt = bits_dec;
              if (bits_dec == 4'd0) begin
                rx_shift_nxt = rx_merged;
                rx_last_nxt  = rx_merged;
                rx_done      = 1'b1;
                phase_nxt    = PH_IDLE;
                sub_step_nxt = 2'd0;
              end else begin
                pins_nxt.sck   = 1'b0;
                rx_shift_nxt   = {rx_merged[6:0], 1'b0};
                sub_step_nxt   = 2'd1;
                wait_count_nxt = latched_delay_r;
              end
            end
          end
          PH_CLOSE: begin
            if (sub_step_r == 2'd0) begin
              pins_nxt.sck   = 1'b0;
              sub_step_nxt   = 2'd1;
              wait_count_nxt = latched_delay_r;
            end else if (sub_step_r == 2'd1) begin
              pins_nxt.mosi  = 1'b1;
              sub_step_nxt   = 2'd2;
              wait_count_nxt = latched_delay_r;
            end else begin
              // release the select of the device taken at open
              if (active_dev_r == DEV_FIRST) begin
                pins_nxt.cs_first_n = 1'b1;
              end else if (active_dev_r == DEV_SECOND) begin
                pins_nxt.cs_second_n = 1'b1;
              end
              phase_nxt    = PH_IDLE;
              sub_step_nxt = 2'd0;
            end
          end
          default: begin
            phase_nxt    = PH_IDLE;
            sub_step_nxt = 2'd0;
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold the result until the consumer takes the transfer.
  // --------------------------------------------------------------------------
  pins_t      res_pins_r;
  logic [7:0] res_rx_byte_r;
  logic       res_rx_valid_r;
  logic       res_busy_r;
  logic       res_rejected_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_pins_r     <= pins_nxt;
      res_rx_byte_r  <= rx_last_nxt;
      res_rx_valid_r <= rx_done;
      res_busy_r     <= (phase_nxt != PH_IDLE);
      res_rejected_r <= rejected;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_cs_first_n  = res_pins_r.cs_first_n;
  assign out_cs_second_n = res_pins_r.cs_second_n;
  assign out_sck         = res_pins_r.sck;
  assign out_mosi        = res_pins_r.mosi;
  assign out_rx_byte     = res_rx_byte_r;
  assign out_rx_valid    = res_rx_valid_r;
  assign out_busy_res    = res_busy_r;
  assign out_rejected    = res_rejected_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_CLKD(a_idle_no_wait, (phase_r == PH_IDLE) |-> (wait_count_r == '0),
    "wait counter left running in idle")
  `ASSERT_CLKD(a_shift_bits_left,
    (phase_r == PH_WRITE || phase_r == PH_READ) |-> (bits_left_r != 4'd0),
    "byte phase running with no bits left")
  `ASSERT_NEVER_BOTH(a_done_not_rejected, out_vld_r && res_rx_valid_r, res_rejected_r,
    "read completion and rejection on the same result")
  `ASSERT_CLKD(a_done_goes_idle, (out_vld_r && res_rx_valid_r) |-> !res_busy_r,
    "read completed but sequence still busy")

endmodule
